// File: rtl/rc_pulse_width_capture_top_defines.svh
// Assertion macros shared by the pulse width capture RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef RC_PULSE_WIDTH_CAPTURE_TOP_DEFINES_SVH
`define RC_PULSE_WIDTH_CAPTURE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RCPW_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RCPW_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/rcpw_pkg.sv
// Shared types, field widths and codes for the pulse width capture block.
// No dependencies; every RTL .sv file other than this one uses this package.
`default_nettype none

package rcpw_pkg;

    // Field and register widths
    localparam int ACT_W       = 2;
    localparam int CH_FIELD_W  = 2;
    localparam int CAP_W       = 32;
    localparam int STATUS_W    = 2;
    localparam int PW_W        = 32;
    localparam int ENABLE_W    = 4;
    localparam int PERIOD_W    = 32;
    localparam int SHIFT_CFG_W = 4;
    localparam int WRAP_W      = 16;
    localparam int AVG_W       = 48;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    // Defaults for top-level parameters, and the command queue depth
    localparam int NUM_CHANNELS_DEF = 4;
    localparam int FRAC_BITS_DEF    = 14;
    localparam int QUEUE_DEPTH      = 2;

    // Register reset values
    localparam logic [ENABLE_W-1:0]    ENABLE_RST = '0;
    localparam logic [PERIOD_W-1:0]    PERIOD_RST = 32'd599999;
    localparam logic [SHIFT_CFG_W-1:0] SHIFT_RST  = 4'd4;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHIFT  = 2'd2;

    // Action codes of an input transaction
    localparam logic [ACT_W-1:0] ACT_TICK    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_CAPTURE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ    = 2'd2;
    localparam logic [ACT_W-1:0] ACT_NONE    = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_DISABLED  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BAD_LEVEL = 2'd2;

    // Classified operation handed from front to back
    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_CAPTURE  = 3'd1,
        OP_READ     = 3'd2,
        OP_NOP      = 3'd3,
        OP_DISABLED = 3'd4
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic [CH_FIELD_W-1:0] channel;
        logic                  level;
        logic [CAP_W-1:0]      capture_value;
        logic                  wrap_same_irq;
    } cmd_t;

    typedef struct packed {
        logic [ENABLE_W-1:0]    channel_enable;
        logic [PERIOD_W-1:0]    timer_period;
        logic [SHIFT_CFG_W-1:0] avg_shift;
    } cfg_t;

endpackage

`default_nettype wire

// File: rtl/rcpw_if.sv
// Valid/ready channel interfaces for input items and results.
// Depends on rcpw_pkg for field widths.
`default_nettype none

interface rcpw_item_if;
    logic                              valid;
    logic                              ready;
    logic [rcpw_pkg::ACT_W-1:0]        action;
    logic [rcpw_pkg::CH_FIELD_W-1:0]   channel;
    logic                              level;
    logic [rcpw_pkg::CAP_W-1:0]        capture_value;
    logic                              wrap_same_irq;

    modport source (output valid, action, channel, level, capture_value, wrap_same_irq,
                    input ready);
    modport sink   (input valid, action, channel, level, capture_value, wrap_same_irq,
                    output ready);
endinterface

interface rcpw_result_if;
    logic                              valid;
    logic                              ready;
    logic [rcpw_pkg::STATUS_W-1:0]     status;
    logic signed [rcpw_pkg::PW_W-1:0]  pulse_width;

    modport source (output valid, status, pulse_width, input ready);
    modport sink   (input valid, status, pulse_width, output ready);
endinterface

`default_nettype wire

// File: rtl/rcpw_cmd_fifo.sv
// Small command queue between the classifier front end and the execution back end.
// Depends on rcpw_pkg (cmd_t) and the assertion macro header.
`default_nettype none
`include "rc_pulse_width_capture_top_defines.svh"

module rcpw_cmd_fifo #(
    parameter int DEPTH = rcpw_pkg::QUEUE_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  rcpw_pkg::cmd_t     push_cmd,
    input  wire logic          pop,
    output rcpw_pkg::cmd_t     head,
    output logic               empty,
    output logic               full
);
    import rcpw_pkg::*;

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    cmd_t               mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == COUNT_W'(DEPTH));
    assign head  = mem_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `RCPW_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= COUNT_W'(DEPTH), "queue overfilled")
    `RCPW_ASSERT_IMP(a_no_push_full, full, !push, "push into full queue")
    `RCPW_ASSERT_IMP(a_no_pop_empty, pop, !empty, "pop from empty queue")

endmodule

`default_nettype wire

// File: rtl/rcpw_front.sv
// Front end: accepts input transactions, checks channel enable and classifies them.
// Depends on rcpw_pkg and rcpw_item_if; feeds rcpw_cmd_fifo.
`default_nettype none

module rcpw_front #(
    parameter int NUM_CHANNELS = rcpw_pkg::NUM_CHANNELS_DEF
) (
    rcpw_item_if.sink          item,
    input  rcpw_pkg::cfg_t     cfg,
    input  wire logic          queue_full,
    output logic               push,
    output rcpw_pkg::cmd_t     push_cmd
);
    import rcpw_pkg::*;

    logic ch_enabled;

    assign item.ready = !queue_full;
    assign push       = item.valid && !queue_full;

    // A channel beyond the built count is treated as disabled
    assign ch_enabled = (int'(item.channel) < NUM_CHANNELS) &&
                        cfg.channel_enable[item.channel];

    // Classify the transaction
    always_comb
    begin
        push_cmd.channel       = item.channel;
        push_cmd.level         = item.level;
        push_cmd.capture_value = item.capture_value;
        push_cmd.wrap_same_irq = item.wrap_same_irq;
        unique case (item.action)
            ACT_TICK:    push_cmd.op = OP_TICK;
            ACT_CAPTURE: push_cmd.op = ch_enabled ? OP_CAPTURE : OP_DISABLED;
            ACT_READ:    push_cmd.op = ch_enabled ? OP_READ : OP_DISABLED;
            ACT_NONE:    push_cmd.op = OP_NOP;
            default:     push_cmd.op = OP_NOP;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/rcpw_back.sv
// Back end: per-channel state, width arithmetic, averaging and the result register.
// Depends on rcpw_pkg, rcpw_result_if and the assertion macro header.
`default_nettype none
`include "rc_pulse_width_capture_top_defines.svh"

module rcpw_back #(
    parameter int NUM_CHANNELS = rcpw_pkg::NUM_CHANNELS_DEF,
    parameter int FRAC_BITS    = rcpw_pkg::FRAC_BITS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  rcpw_pkg::cfg_t     cfg,
    input  rcpw_pkg::cmd_t     head,
    input  wire logic          empty,
    output logic               pop,
    rcpw_result_if.source      result
);
    import rcpw_pkg::*;

    localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int INT_W    = AVG_W - FRAC_BITS;
    localparam int WRAPS_W  = WRAP_W + 1;
    localparam int PROD_W   = WRAPS_W + PERIOD_W + 1;
    localparam int SUM_W    = PROD_W + 2;
    localparam int FOLD_W   = AVG_W + 2;
    localparam int SHIFT_W  = $clog2(FRAC_BITS + 1);

    localparam logic signed [SUM_W-1:0] W_MAX =
        {{(SUM_W - INT_W + 1){1'b0}}, {(INT_W - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] W_MIN = ~W_MAX;
    localparam logic signed [FOLD_W-1:0] A_MAX =
        {{(FOLD_W - AVG_W + 1){1'b0}}, {(AVG_W - 1){1'b1}}};
    localparam logic signed [FOLD_W-1:0] A_MIN = ~A_MAX;
    localparam logic signed [AVG_W-1:0] RD_MAX =
        {{(AVG_W - PW_W + 1){1'b0}}, {(PW_W - 1){1'b1}}};
    localparam logic signed [AVG_W-1:0] RD_MIN = ~RD_MAX;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MUL   = 4'b0010,
        ST_WIDTH = 4'b0100,
        ST_AVG   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Per-channel state
    logic                    last_level_reg [NUM_CHANNELS];
    logic                    last_level_next [NUM_CHANNELS];
    logic [CAP_W-1:0]        rise_reg [NUM_CHANNELS];
    logic [CAP_W-1:0]        rise_next [NUM_CHANNELS];
    logic signed [AVG_W-1:0] avg_reg [NUM_CHANNELS];
    logic signed [AVG_W-1:0] avg_next [NUM_CHANNELS];
    logic [WRAP_W-1:0]       wrap_reg [NUM_CHANNELS];
    logic [WRAP_W-1:0]       wrap_next [NUM_CHANNELS];

    // Capture pipeline payload
    cmd_t                      cmd_reg, cmd_next;
    logic signed [WRAPS_W-1:0] wraps_reg, wraps_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [INT_W-1:0]   width_reg, width_next;

    // Result register
    logic                    res_valid_reg, res_valid_next;
    logic [STATUS_W-1:0]     res_status_reg, res_status_next;
    logic signed [PW_W-1:0]  res_pw_reg, res_pw_next;

    logic                      out_free;
    logic [CH_IDX_W-1:0]       head_idx, cur_idx;
    logic                      late_capture;
    logic signed [WRAPS_W-1:0] wraps_head;
    logic signed [PROD_W-1:0]  prod_calc;
    logic signed [SUM_W-1:0]   prod_ext, cap_ext, rise_ext, sum_calc;
    logic signed [INT_W-1:0]   width_calc;
    logic [SHIFT_W-1:0]        shift_eff, up_shift;
    logic signed [FOLD_W-1:0]  avg_ext, width_ext, fold_calc;
    logic signed [AVG_W-1:0]   fold_sat, load_val, rd_int;
    logic signed [PW_W-1:0]    rd_sat;
    logic                      prev_level;

    assign result.valid       = res_valid_reg;
    assign result.status      = res_status_reg;
    assign result.pulse_width = res_pw_reg;

    assign out_free = !res_valid_reg || result.ready;
    assign head_idx = CH_IDX_W'(head.channel);
    assign cur_idx  = CH_IDX_W'(cmd_reg.channel);

    // A capture is popped without waiting for the result slot; other ops need the result slot
    assign pop = (state_reg == ST_IDLE) && !empty &&
                 ((head.op == OP_CAPTURE) || out_free);

    // Wrap correction: a wrap in the same interrupt that lands after the capture
    assign late_capture = head.wrap_same_irq &&
                          (head.capture_value > (cfg.timer_period >> 1));
    assign wraps_head   = $signed({1'b0, wrap_reg[head_idx]}) -
                          $signed({{(WRAPS_W - 1){1'b0}}, late_capture});

    // wraps * period
    assign prod_calc = PROD_W'(wraps_reg) * PROD_W'($signed({1'b0, cfg.timer_period}));

    // width = wraps * period + capture - start, saturated to the integer range
    assign prod_ext = {{(SUM_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign cap_ext  = {{(SUM_W - CAP_W){1'b0}}, cmd_reg.capture_value};
    assign rise_ext = {{(SUM_W - CAP_W){1'b0}}, rise_reg[cur_idx]};
    assign sum_calc = prod_ext + cap_ext - rise_ext;

    always_comb
    begin
        if (sum_calc > W_MAX)
        begin
            width_calc = W_MAX[INT_W-1:0];
        end
        else if (sum_calc < W_MIN)
        begin
            width_calc = W_MIN[INT_W-1:0];
        end
        else
        begin
            width_calc = sum_calc[INT_W-1:0];
        end
    end

    // Exponential average fold
    assign shift_eff = (int'(cfg.avg_shift) > FRAC_BITS) ? SHIFT_W'(FRAC_BITS)
                                                         : SHIFT_W'(cfg.avg_shift);
    assign up_shift  = SHIFT_W'(FRAC_BITS) - shift_eff;
    assign avg_ext   = {{(FOLD_W - AVG_W){avg_reg[cur_idx][AVG_W-1]}}, avg_reg[cur_idx]};
    assign width_ext = {{(FOLD_W - INT_W){width_reg[INT_W-1]}}, width_reg};
    assign fold_calc = avg_ext - (avg_ext >>> shift_eff) + (width_ext <<< up_shift);
    assign load_val  = AVG_W'(width_ext <<< FRAC_BITS);

    always_comb
    begin
        if (fold_calc > A_MAX)
        begin
            fold_sat = A_MAX[AVG_W-1:0];
        end
        else if (fold_calc < A_MIN)
        begin
            fold_sat = A_MIN[AVG_W-1:0];
        end
        else
        begin
            fold_sat = fold_calc[AVG_W-1:0];
        end
    end

    // Read: integer part of the average, saturated to 32 bits
    assign rd_int = avg_reg[head_idx] >>> FRAC_BITS;

    always_comb
    begin
        if (rd_int > RD_MAX)
        begin
            rd_sat = RD_MAX[PW_W-1:0];
        end
        else if (rd_int < RD_MIN)
        begin
            rd_sat = RD_MIN[PW_W-1:0];
        end
        else
        begin
            rd_sat = rd_int[PW_W-1:0];
        end
    end

    assign prev_level = last_level_reg[cur_idx];

    // Sequencer and state update
    always_comb
    begin
        state_next      = state_reg;
        last_level_next = last_level_reg;
        rise_next       = rise_reg;
        avg_next        = avg_reg;
        wrap_next       = wrap_reg;
        cmd_next        = cmd_reg;
        wraps_next      = wraps_reg;
        prod_next       = prod_reg;
        width_next      = width_reg;
        res_valid_next  = res_valid_reg;
        res_status_next = res_status_reg;
        res_pw_next     = res_pw_reg;

        if (result.ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    if (head.op == OP_CAPTURE)
                    begin
                        cmd_next   = head;
                        wraps_next = wraps_head;
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        res_valid_next  = 1'b1;
                        res_status_next = STAT_OK;
                        res_pw_next     = '0;
                        case (head.op)
                            OP_TICK:
                            begin
                                for (int c = 0; c < NUM_CHANNELS; c++)
                                begin
                                    if (wrap_reg[c] != '1)
                                    begin
                                        wrap_next[c] = wrap_reg[c] + WRAP_W'(1);
                                    end
                                end
                            end
                            OP_READ:     res_pw_next     = rd_sat;
                            OP_DISABLED: res_status_next = STAT_DISABLED;
                            default:     res_status_next = STAT_OK;
                        endcase
                    end
                end
            end
            ST_MUL:
            begin
                prod_next  = prod_calc;
                state_next = ST_WIDTH;
            end
            ST_WIDTH:
            begin
                width_next = width_calc;
                state_next = ST_AVG;
            end
            ST_AVG:
            begin
                if (out_free)
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = STAT_OK;
                    res_pw_next     = '0;
                    if (!prev_level && cmd_reg.level)
                    begin
                        rise_next[cur_idx] = cmd_reg.capture_value;
                    end
                    else if (prev_level && !cmd_reg.level)
                    begin
                        if (avg_reg[cur_idx] == '0)
                        begin
                            avg_next[cur_idx] = load_val;
                        end
                        else if (width_reg > INT_W'(0))
                        begin
                            avg_next[cur_idx] = fold_sat;
                        end
                    end
                    else
                    begin
                        res_status_next = STAT_BAD_LEVEL;
                    end
                    wrap_next[cur_idx]       = '0;
                    last_level_next[cur_idx] = cmd_reg.level;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                last_level_reg[c] <= 1'b1;
                rise_reg[c]       <= '0;
                avg_reg[c]        <= '0;
                wrap_reg[c]       <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            res_valid_reg  <= res_valid_next;
            last_level_reg <= last_level_next;
            rise_reg       <= rise_next;
            avg_reg        <= avg_next;
            wrap_reg       <= wrap_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        wraps_reg      <= wraps_next;
        prod_reg       <= prod_next;
        width_reg      <= width_next;
        res_status_reg <= res_status_next;
        res_pw_reg     <= res_pw_next;
    end

    `RCPW_ASSERT_IMP(a_busy_is_capture, state_reg != ST_IDLE, cmd_reg.op == OP_CAPTURE, "capture sequence running a non-capture op")
    `RCPW_ASSERT_NXT(a_quick_op_result, pop && (head.op != OP_CAPTURE), res_valid_reg, "quick op did not load a result")
    `RCPW_ASSERT_NXT(a_capture_done, (state_reg == ST_AVG) && out_free, (state_reg == ST_IDLE) && res_valid_reg, "capture finish did not return to idle with a result")

endmodule

`default_nettype wire

// File: rtl/rc_pulse_width_capture_top.sv
// Timing: an accepted item is written into the queue; a tick, read, unused or disabled item
// is popped once the result register is free and loads it; a capture passes the multiply,
// width and average steps and loads its result in the average step once the register is free.
// While a capture is worked on, no item is popped, but the 2-entry queue still accepts items.
// Reset: levels read high, counts and averages zero, registers at defaults; no clearing pass.
`default_nettype none

module rc_pulse_width_capture_top #(
    parameter int NUM_CHANNELS = rcpw_pkg::NUM_CHANNELS_DEF,
    parameter int FRAC_BITS    = rcpw_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [rcpw_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [rcpw_pkg::CFG_DATA_W-1:0]   cfg_data,
    rcpw_item_if.sink                              item,
    rcpw_result_if.source                          result
);
    import rcpw_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic queue_full, queue_empty, push, pop;
    cmd_t push_cmd, head;

    // Configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ENABLE: cfg_next.channel_enable = cfg_data[ENABLE_W-1:0];
                CFG_PERIOD: cfg_next.timer_period   = cfg_data[PERIOD_W-1:0];
                CFG_SHIFT:  cfg_next.avg_shift      = cfg_data[SHIFT_CFG_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.channel_enable <= ENABLE_RST;
            cfg_reg.timer_period   <= PERIOD_RST;
            cfg_reg.avg_shift      <= SHIFT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    rcpw_front #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_front (
        .item       (item),
        .cfg        (cfg_reg),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    rcpw_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (queue_empty),
        .full     (queue_full)
    );

    rcpw_back #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .head   (head),
        .empty  (queue_empty),
        .pop    (pop),
        .result (result)
    );

endmodule

`default_nettype wire

// File: tb/tb_rc_pulse_width_capture_top.sv
// Self-checking testbench for the RC servo pulse width capture block.
// Depends on rcpw_pkg, the rcpw_item_if/rcpw_result_if interfaces and the
// rc_pulse_width_capture_top RTL.
`default_nettype none

module tb_rc_pulse_width_capture_top;

    import rcpw_pkg::*;

    localparam int     CLK_HALF    = 5;
    localparam int     RESET_CYCLES = 6;
    localparam int     NCH         = NUM_CHANNELS_DEF;
    localparam int     FRAC        = FRAC_BITS_DEF;
    localparam int     DRAIN_CYCLES = 12;
    localparam int     CYCLE_LIMIT = 2000000;
    localparam int     MAX_REPORTS = 10;
    localparam logic [WRAP_W-1:0]      WRAP_TOP   = '1;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    // Fixed-point limits of the width and of the running average
    localparam longint FRAC_ONE = longint'(1) <<< FRAC;
    localparam longint W_HI     = (longint'(1) <<< (AVG_W - 1 - FRAC)) - 1;
    localparam longint W_LO     = -W_HI - 1;
    localparam longint AVG_HI   = (longint'(1) <<< (AVG_W - 1)) - 1;
    localparam longint AVG_LO   = -AVG_HI - 1;
    localparam longint I32_HI   = 64'sd2147483647;
    localparam longint I32_LO   = -I32_HI - 1;

    typedef struct {
        logic [ACT_W-1:0]      action;
        logic [CH_FIELD_W-1:0] channel;
        logic                  level;
        logic [CAP_W-1:0]      capture_value;
        logic                  wrap_same_irq;
    } pulse_evt_t;

    typedef struct {
        logic [STATUS_W-1:0]     status;
        logic signed [PW_W-1:0]  pulse_width;
    } width_res_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    rcpw_item_if   item_ch ();
    rcpw_result_if result_ch ();

    rc_pulse_width_capture_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (result_ch)
    );

    // Predictor copy of the registers and per-channel state
    logic [ENABLE_W-1:0]    en_mask;
    logic [PERIOD_W-1:0]    period;
    logic [SHIFT_CFG_W-1:0] shift;
    logic                   pin_lvl   [NCH];
    logic [CAP_W-1:0]       start_cnt [NCH];
    longint                 avg_fx    [NCH];
    logic [WRAP_W-1:0]      wraps     [NCH];

    // Level each channel will hold once queued captures are applied
    logic                   gen_lvl   [NCH];

    pulse_evt_t pending_q  [$];
    width_res_t expected_q [$];

    logic idle_en;
    int   gap_left;
    int   stall_left;
    int   n_queued;
    int   n_accepted;
    int   n_checked;
    int   n_mismatch;
    int   n_settings;
    int   cyc;

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Advance the channel state by one input transaction; return its result
    function automatic width_res_t capture_step(pulse_evt_t ev);
        width_res_t res;
        int         ch;
        int         s;
        longint     span;
        longint     w;
        longint     acc;
        res.status      = STAT_OK;
        res.pulse_width = '0;
        ch = int'(ev.channel);
        case (ev.action)
            ACT_TICK: begin
                // every channel counts the wrap, enabled or not
                for (int c = 0; c < NCH; c++)
                    if (wraps[c] != WRAP_TOP)
                        wraps[c] = wraps[c] + WRAP_W'(1);
            end
            ACT_CAPTURE: begin
                if (!en_mask[ch])
                    res.status = STAT_DISABLED;
                else
                begin
                    span = longint'({48'd0, wraps[ch]});
                    // wrap seen in the same interrupt but after this capture
                    if (ev.wrap_same_irq && (ev.capture_value > (period >> 1)))
                        span = span - 1;
                    if (!pin_lvl[ch] && ev.level)
                        start_cnt[ch] = ev.capture_value;
                    else if (pin_lvl[ch] && !ev.level)
                    begin
                        w = span * longint'({32'd0, period})
                            + longint'({32'd0, ev.capture_value})
                            - longint'({32'd0, start_cnt[ch]});
                        w = clip(w, W_LO, W_HI);
                        if (avg_fx[ch] == 0)
                            avg_fx[ch] = w * FRAC_ONE;
                        else if (w > 0)
                        begin
                            s   = (int'(shift) > FRAC) ? FRAC : int'(shift);
                            acc = avg_fx[ch];
                            acc = acc - (acc >>> s) + w * (longint'(1) <<< (FRAC - s));
                            avg_fx[ch] = clip(acc, AVG_LO, AVG_HI);
                        end
                    end
                    else
                        res.status = STAT_BAD_LEVEL;
                    wraps[ch]   = '0;
                    pin_lvl[ch] = ev.level;
                end
            end
            ACT_READ: begin
                if (!en_mask[ch])
                    res.status = STAT_DISABLED;
                else
                    res.pulse_width = 32'(clip(avg_fx[ch] >>> FRAC, I32_LO, I32_HI));
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic void push_evt(logic [ACT_W-1:0] act, logic [CH_FIELD_W-1:0] ch,
                                     logic lvl, logic [CAP_W-1:0] cap, logic wf);
        pulse_evt_t ev;
        ev.action        = act;
        ev.channel       = ch;
        ev.level         = lvl;
        ev.capture_value = cap;
        ev.wrap_same_irq = wf;
        pending_q.push_back(ev);
        n_queued++;
    endfunction

    // Capture count, mostly inside the current timer period
    function automatic logic [CAP_W-1:0] rand_cap();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return period;
            2:       return $urandom;
            default: return $urandom_range(period, 0);
        endcase
    endfunction

    // Clock
    always #(CLK_HALF) clk = ~clk;

    // Cycle counter and watchdog
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still pending",
                     cyc, expected_q.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // Item driver: predicts each accepted transaction, then presents the next one
    always @(posedge clk)
    begin : item_driver
        pulse_evt_t nxt;
        if (!rst_n)
            item_ch.valid <= 1'b0;
        else
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                nxt.action        = item_ch.action;
                nxt.channel       = item_ch.channel;
                nxt.level         = item_ch.level;
                nxt.capture_value = item_ch.capture_value;
                nxt.wrap_same_irq = item_ch.wrap_same_irq;
                expected_q.push_back(capture_step(nxt));
                n_accepted++;
            end
            if (!item_ch.valid || item_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    item_ch.valid <= 1'b0;
                end
                else if (pending_q.size() > 0)
                begin
                    nxt = pending_q.pop_front();
                    item_ch.action        <= nxt.action;
                    item_ch.channel       <= nxt.channel;
                    item_ch.level         <= nxt.level;
                    item_ch.capture_value <= nxt.capture_value;
                    item_ch.wrap_same_irq <= nxt.wrap_same_irq;
                    item_ch.valid         <= 1'b1;
                    if (idle_en && $urandom_range(0, 4) == 0)
                        gap_left = $urandom_range(1, 6);
                end
                else
                    item_ch.valid <= 1'b0;
            end
        end
    end

    // Result monitor: checks against the oldest expectation, stalls at random while idle_en is set
    always @(posedge clk)
    begin : result_monitor
        width_res_t want;
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    if (n_mismatch < MAX_REPORTS)
                        $display("Unexpected result: status %0d width %0d",
                                 result_ch.status, result_ch.pulse_width);
                    n_mismatch++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (result_ch.status !== want.status ||
                        result_ch.pulse_width !== want.pulse_width)
                    begin
                        if (n_mismatch < MAX_REPORTS)
                            $display("Result %0d: expected status %0d width %0d, got %0d %0d",
                                     n_checked, want.status, want.pulse_width,
                                     result_ch.status, result_ch.pulse_width);
                        n_mismatch++;
                    end
                    n_checked++;
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else if (idle_en && $urandom_range(0, 6) == 0)
            begin
                stall_left = $urandom_range(0, 5);
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // Register write, mirrored into the predictor (block is idle here)
    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_ENABLE: en_mask = val[ENABLE_W-1:0];
            CFG_PERIOD: period  = val;
            CFG_SHIFT:  shift   = val[SHIFT_CFG_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_setting(input logic [ENABLE_W-1:0] en, input logic [PERIOD_W-1:0] per,
                                 input logic [SHIFT_CFG_W-1:0] sh);
        cfg_write(CFG_ENABLE, CFG_DATA_W'(en));
        cfg_write(CFG_PERIOD, per);
        cfg_write(CFG_SHIFT, CFG_DATA_W'(sh));
        n_settings++;
    endtask

    // Hold off until every queued transaction has produced its result
    task automatic settle();
        while (n_checked < n_queued)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Mostly well-formed rise/fall pairs with random content, plus noise
    task automatic random_burst(input int n_items);
        int made;
        int pick;
        int ch;
        int k;
        logic lvl;
        made = 0;
        gen_lvl = pin_lvl;
        while (made < n_items)
        begin
            pick = $urandom_range(0, 99);
            ch   = $urandom_range(0, NCH - 1);
            if (pick < 55)
            begin
                if (gen_lvl[ch])
                begin
                    push_evt(ACT_CAPTURE, CH_FIELD_W'(ch), 1'b0, rand_cap(),
                             $urandom_range(0, 3) == 0);
                    made++;
                end
                push_evt(ACT_CAPTURE, CH_FIELD_W'(ch), 1'b1, rand_cap(),
                         $urandom_range(0, 3) == 0);
                k = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
                repeat (k) push_evt(ACT_TICK, CH_FIELD_W'($urandom), 1'($urandom), $urandom,
                                    1'($urandom));
                push_evt(ACT_CAPTURE, CH_FIELD_W'(ch), 1'b0, rand_cap(),
                         $urandom_range(0, 2) == 0);
                made += 2 + k;
                if (en_mask[ch])
                    gen_lvl[ch] = 1'b0;
            end
            else if (pick < 72)
            begin
                push_evt(ACT_READ, CH_FIELD_W'(ch), 1'($urandom), $urandom, 1'($urandom));
                made++;
            end
            else if (pick < 80)
            begin
                k = $urandom_range(1, 4);
                repeat (k) push_evt(ACT_TICK, CH_FIELD_W'($urandom), 1'($urandom), $urandom,
                                    1'($urandom));
                made += k;
            end
            else if (pick < 93)
            begin
                // arbitrary edge, often a repeated level
                lvl = 1'($urandom);
                push_evt(ACT_CAPTURE, CH_FIELD_W'(ch), lvl, $urandom, 1'($urandom));
                if (en_mask[ch])
                    gen_lvl[ch] = lvl;
                made++;
            end
            else
            begin
                push_evt(ACT_NONE, CH_FIELD_W'(ch), 1'($urandom), $urandom, 1'($urandom));
                made++;
            end
        end
    endtask

    initial
    begin
        clk        = 1'b0;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        item_ch.valid         = 1'b0;
        item_ch.action        = ACT_NONE;
        item_ch.channel       = '0;
        item_ch.level         = 1'b0;
        item_ch.capture_value = '0;
        item_ch.wrap_same_irq = 1'b0;
        result_ch.ready       = 1'b0;
        idle_en    = 1'b1;
        gap_left   = 0;
        stall_left = 0;
        n_queued   = 0;
        n_accepted = 0;
        n_checked  = 0;
        n_mismatch = 0;
        n_settings = 0;
        cyc        = 0;
        en_mask    = ENABLE_RST;
        period     = PERIOD_RST;
        shift      = SHIFT_RST;
        for (int c = 0; c < NCH; c++)
        begin
            pin_lvl[c]   = 1'b1;
            start_cnt[c] = '0;
            avg_fx[c]    = 0;
            wraps[c]     = '0;
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: small period, channel 3 off, shift 0 replaces the average
        cfg_write(CFG_UNUSED, '1);
        apply_setting(4'b0111, 32'd1000, 4'd0);
        push_evt(ACT_READ,    2'd0, 1'b0, 32'd0,     1'b0);
        push_evt(ACT_CAPTURE, 2'd3, 1'b1, 32'd5,     1'b0);
        push_evt(ACT_READ,    2'd3, 1'b0, 32'd0,     1'b0);
        push_evt(ACT_NONE,    2'd3, 1'b1, '1,        1'b1);
        push_evt(ACT_CAPTURE, 2'd0, 1'b1, 32'd100,   1'b0);  // high after reset: bad level
        push_evt(ACT_CAPTURE, 2'd0, 1'b0, 32'd200,   1'b0);  // first width loads average
        push_evt(ACT_CAPTURE, 2'd0, 1'b1, 32'd900,   1'b0);
        push_evt(ACT_TICK,    2'd0, 1'b0, 32'd0,     1'b0);
        push_evt(ACT_CAPTURE, 2'd0, 1'b0, 32'd50,    1'b0);  // spans one wrap
        push_evt(ACT_READ,    2'd0, 1'b0, 32'd0,     1'b0);
        push_evt(ACT_CAPTURE, 2'd0, 1'b1, 32'd700,   1'b0);
        push_evt(ACT_TICK,    2'd0, 1'b0, 32'd0,     1'b0);
        push_evt(ACT_CAPTURE, 2'd0, 1'b0, 32'd800,   1'b1);  // wrap taken back
        push_evt(ACT_CAPTURE, 2'd0, 1'b0, 32'd0,     1'b0);  // repeated low
        push_evt(ACT_READ,    2'd0, 1'b0, 32'd0,     1'b0);
        push_evt(ACT_CAPTURE, 2'd1, 1'b0, 32'd10,    1'b0);
        push_evt(ACT_CAPTURE, 2'd1, 1'b1, 32'd999,   1'b0);
        push_evt(ACT_CAPTURE, 2'd1, 1'b0, 32'd600,   1'b1);  // wraps of -1: negative, ignored
        push_evt(ACT_READ,    2'd1, 1'b0, 32'd0,     1'b0);
        push_evt(ACT_CAPTURE, 2'd2, 1'b0, 32'd0,     1'b0);  // zero width keeps average zero
        push_evt(ACT_TICK,    2'd0, 1'b0, 32'd0,     1'b0);
        push_evt(ACT_CAPTURE, 2'd2, 1'b1, '1,        1'b0);
        push_evt(ACT_READ,    2'd2, 1'b0, 32'd0,     1'b0);
        push_evt(ACT_CAPTURE, 2'd0, 1'b1, 32'd0,     1'b1);
        settle();

        // Largest period: width and read saturation, shift above the fraction bits
        apply_setting(4'hF, '1, 4'd15);
        push_evt(ACT_CAPTURE, 2'd2, 1'b0, '1,        1'b1);  // negative load, read floors low
        push_evt(ACT_READ,    2'd2, 1'b0, 32'd0,     1'b0);
        push_evt(ACT_CAPTURE, 2'd3, 1'b0, '1,        1'b0);  // wraps counted while disabled
        push_evt(ACT_READ,    2'd3, 1'b0, 32'd0,     1'b0);
        push_evt(ACT_CAPTURE, 2'd3, 1'b1, 32'd5,     1'b0);
        push_evt(ACT_TICK,    2'd0, 1'b0, 32'd0,     1'b0);
        push_evt(ACT_TICK,    2'd0, 1'b0, 32'd0,     1'b0);
        push_evt(ACT_CAPTURE, 2'd3, 1'b0, 32'h7FFF_FFFF, 1'b0);
        push_evt(ACT_READ,    2'd3, 1'b0, 32'd0,     1'b0);
        push_evt(ACT_READ,    2'd0, 1'b0, 32'd0,     1'b0);
        settle();

        // Smallest period, then random traffic with idling on both sides
        idle_en = 1'b1;
        apply_setting(4'hF, 32'd1, 4'd1);
        push_evt(ACT_CAPTURE, 2'd0, 1'b0, 32'd0, 1'b0);  // falling edge at a period of one
        push_evt(ACT_READ,    2'd0, 1'b0, 32'd0, 1'b0);
        random_burst(150);
        settle();

        // Half the channels, shift 13; sender pauses until drained mid-way
        apply_setting(4'b1010, 32'd599999, 4'd13);
        random_burst(100);
        settle();
        random_burst(100);
        settle();

        apply_setting(4'h0, 32'd20000, 4'd7);
        random_burst(60);
        settle();

        apply_setting(4'hF, '1, 4'd14);
        random_burst(150);
        settle();

        apply_setting(ENABLE_W'($urandom_range(1, 15)), $urandom_range(32'hFFFF_FFFF, 1), 4'd0);
        random_burst(150);
        settle();

        // Final stretch runs at full rate
        idle_en = 1'b0;
        apply_setting(4'hF, 32'd20000, 4'd4);
        random_burst(150);
        settle();

        $display("Covered %0d input transactions over %0d register settings,",
                 n_accepted, n_settings);
        $display("including directed edge cases and random edge traffic; %0d results checked",
                 n_checked);
        if (n_mismatch == 0 && expected_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
+incdir+rtl
rtl/rcpw_pkg.sv
rtl/rcpw_if.sv
rtl/rcpw_cmd_fifo.sv
rtl/rcpw_front.sv
rtl/rcpw_back.sv
rtl/rc_pulse_width_capture_top.sv
tb/tb_rc_pulse_width_capture_top.sv
